// ----- design/bffp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bffp_pkg
// Shared types and constants of the banked first-fit placer.
// ----------------------------------------------------------------------------
package bffp_pkg;

    localparam int ADDR_W = 16;
    localparam int BNUM_W = 9;

    localparam logic [1:0] REG_REGION_START  = 2'd0;
    localparam logic [1:0] REG_REGION_LENGTH = 2'd1;
    localparam logic [1:0] REG_FIRST_BANK    = 2'd2;
    localparam logic [1:0] REG_LAST_BANK     = 2'd3;

    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ROOM    = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BANK,
        S_BANK_DATA,
        S_SEG_RD,
        S_SEG_DATA,
        S_CHECK,
        S_EVAL,
        S_FOUND,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WR_A,
        S_WR_B,
        S_WR_CNT,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- design/bffp_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bffp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bffp_ram #(
    parameter int WIDTH = 32,
    parameter int AW    = 13,
    parameter int DEPTH = 8192
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- design/banked_first_fit_placer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// banked_first_fit_placer
// First-fit placement of sections into per-bank free-segment tables.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_ready) takes one request item: place or clear.
//  Output channel (out_valid/out_ready) returns one item per request:
//  status, placed_address, placed_bank.
//  cfg_write/cfg_index/cfg_data write the region registers, one per cycle;
//  write them only while the block is idle (the block itself does not enforce it).
//  Flow: a zero-size place goes straight to its result. A place walks banks
//  in order, reading each bank's status and then each segment or candidate
//  visited from the segment table, then moves table entries one by one on a
//  remove or split and writes back the segments and the bank count. A clear
//  sweeps the bank status memory. One item is in work at a time;
//  in_ready is high only when the sequencer is idle.
//  Reset: the bank status memory is swept after reset, during which no item
//  is accepted; config writes are taken at all times.
//  A stalled receiver holds the result in the output register; the next item
//  is still accepted and its result waits until the register is free.
// ----------------------------------------------------------------------------
module banked_first_fit_placer #(
    parameter int MAX_BANKS    = 512,
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [bffp_pkg::ADDR_W-1:0]    request_size,
    input  wire logic                           bank_is_fixed,
    input  wire logic [bffp_pkg::BNUM_W-1:0]    wanted_bank,
    input  wire logic                           address_is_fixed,
    input  wire logic [bffp_pkg::ADDR_W-1:0]    wanted_address,
    input  wire logic                           align_is_fixed,
    input  wire logic [bffp_pkg::ADDR_W-1:0]    align_mask,
    input  wire logic [bffp_pkg::ADDR_W-1:0]    align_offset,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          status,
    output logic [bffp_pkg::ADDR_W-1:0]         placed_address,
    output logic [bffp_pkg::BNUM_W-1:0]         placed_bank,
    input  wire logic                           cfg_write,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [bffp_pkg::ADDR_W-1:0]    cfg_data
);

    import bffp_pkg::*;

    localparam int SEG_W     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);
    localparam int BANK_W    = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int SEG_AW    = BANK_W + SEG_W;
    localparam int SEG_DEPTH = MAX_BANKS * (2 ** SEG_W);
    localparam int BW_W      = CNT_W + 1;
    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_SEGMENTS);
    localparam logic [BANK_W-1:0] LAST_IDX = BANK_W'(MAX_BANKS - 1);

    // configuration
    logic [ADDR_W-1:0] region_start_reg, region_length_reg;
    logic [BNUM_W-1:0] first_bank_reg, last_bank_reg;

    // control
    state_t            state_reg, state_next;
    logic [BANK_W-1:0] clr_idx_reg, clr_idx_next;
    logic              clr_result_reg, clr_result_next;
    logic              out_valid_reg, out_valid_next;

    // request and work registers
    logic [ADDR_W-1:0] size_reg, size_next;
    logic              af_reg, af_next;
    logic [ADDR_W-1:0] waddr_reg, waddr_next;
    logic              alf_reg, alf_next;
    logic [ADDR_W-1:0] mask_reg, mask_next;
    logic [ADDR_W-1:0] ofs_reg, ofs_next;
    logic [BNUM_W:0]   bank_reg, bank_next;
    logic [BNUM_W-1:0] end_reg, end_next;
    logic [BANK_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  n_new_reg, n_new_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] a_reg, a_next;
    logic [ADDR_W-1:0] seg_b_reg, seg_b_next;
    logic [ADDR_W-1:0] seg_z_reg, seg_z_next;
    logic              first_reg, first_next;
    logic              set_a_reg, set_a_next;
    logic              down_reg, down_next;
    logic              split_reg, split_next;
    status_t           res_status_reg, res_status_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [BNUM_W-1:0] res_bank_reg, res_bank_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic [BNUM_W-1:0] out_bank_reg, out_bank_next;

    // memories
    logic                   seg_wr_en, seg_rd_en;
    logic [SEG_AW-1:0]      seg_wr_addr, seg_rd_addr;
    logic [2*ADDR_W-1:0]    seg_wr_data, seg_rd_data;
    logic                   bk_wr_en, bk_rd_en;
    logic [BANK_W-1:0]      bk_wr_addr, bk_rd_addr;
    logic [BW_W-1:0]        bk_wr_data, bk_rd_data;

    // datapath helpers
    logic [ADDR_W:0]   seg_end, a_plus;
    logic [ADDR_W-1:0] a_rel, next_align;
    logic              fits, no_left, no_right;
    logic [BNUM_W:0]   bank_off;
    logic [BNUM_W-1:0] hi_bank;
    logic [CNT_W-1:0]  i_inc, stored_cnt;

    bffp_ram #(
        .WIDTH (2 * ADDR_W),
        .AW    (SEG_AW),
        .DEPTH (SEG_DEPTH)
    ) u_seg_ram (
        .clk     (clk),
        .wr_en   (seg_wr_en),
        .wr_addr (seg_wr_addr),
        .wr_data (seg_wr_data),
        .rd_en   (seg_rd_en),
        .rd_addr (seg_rd_addr),
        .rd_data (seg_rd_data)
    );

    bffp_ram #(
        .WIDTH (BW_W),
        .AW    (BANK_W),
        .DEPTH (MAX_BANKS)
    ) u_bank_ram (
        .clk     (clk),
        .wr_en   (bk_wr_en),
        .wr_addr (bk_wr_addr),
        .wr_data (bk_wr_data),
        .rd_en   (bk_rd_en),
        .rd_addr (bk_rd_addr),
        .rd_data (bk_rd_data)
    );

    assign seg_end    = {1'b0, seg_b_reg} + {1'b0, seg_z_reg};
    assign a_plus     = {1'b0, a_reg} + {1'b0, size_reg};
    assign a_rel      = a_reg - ofs_reg;
    assign next_align = (a_rel & ~mask_reg) + mask_reg + ADDR_W'(1) + ofs_reg;
    assign fits       = (!af_reg || (waddr_reg == a_reg))
                        && (!alf_reg || ((a_rel & mask_reg) == '0))
                        && (a_reg >= seg_b_reg)
                        && (a_plus <= seg_end);
    assign no_left    = (seg_b_reg == a_reg);
    assign no_right   = (seg_end == a_plus);
    assign bank_off   = bank_reg - {1'b0, first_bank_reg};
    assign hi_bank    = (last_bank_reg < first_bank_reg) ? first_bank_reg : last_bank_reg;
    assign i_inc      = i_reg + CNT_W'(1);
    assign stored_cnt = (bk_rd_data[CNT_W-1:0] > MAX_CNT) ? MAX_CNT : bk_rd_data[CNT_W-1:0];

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign placed_address = out_addr_reg;
    assign placed_bank    = out_bank_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        clr_result_next = clr_result_reg;
        size_next       = size_reg;
        af_next         = af_reg;
        waddr_next      = waddr_reg;
        alf_next        = alf_reg;
        mask_next       = mask_reg;
        ofs_next        = ofs_reg;
        bank_next       = bank_reg;
        end_next        = end_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        n_new_next      = n_new_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        a_next          = a_reg;
        seg_b_next      = seg_b_reg;
        seg_z_next      = seg_z_reg;
        first_next      = first_reg;
        set_a_next      = set_a_reg;
        down_next       = down_reg;
        split_next      = split_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_bank_next   = res_bank_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_bank_next   = out_bank_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        seg_wr_en       = 1'b0;
        seg_wr_addr     = {idx_reg, i_reg[SEG_W-1:0]};
        seg_wr_data     = {seg_b_reg, seg_z_reg};
        seg_rd_en       = 1'b0;
        seg_rd_addr     = {idx_reg, i_reg[SEG_W-1:0]};
        bk_wr_en        = 1'b0;
        bk_wr_addr      = idx_reg;
        bk_wr_data      = {1'b1, n_new_reg};
        bk_rd_en        = 1'b0;
        bk_rd_addr      = BANK_W'(bank_off);

        case (state_reg)
            S_CLEAR:
            begin
                bk_wr_en   = 1'b1;
                bk_wr_addr = clr_idx_reg;
                bk_wr_data = '0;
                if (clr_idx_reg == LAST_IDX)
                begin
                    clr_idx_next    = '0;
                    clr_result_next = 1'b0;
                    state_next      = clr_result_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + BANK_W'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    size_next       = request_size;
                    af_next         = address_is_fixed;
                    waddr_next      = wanted_address;
                    alf_next        = align_is_fixed;
                    mask_next       = align_mask;
                    ofs_next        = align_offset;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_bank_next   = '0;
                    if (action == ACT_CLEAR)
                    begin
                        clr_idx_next    = '0;
                        clr_result_next = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    else if (request_size == '0)
                    begin
                        res_addr_next = address_is_fixed ? wanted_address : region_start_reg;
                        res_bank_next = bank_is_fixed ? wanted_bank : first_bank_reg;
                        state_next    = S_DONE;
                    end
                    else if (bank_is_fixed)
                    begin
                        if ((wanted_bank < first_bank_reg) || (wanted_bank > hi_bank))
                        begin
                            res_status_next = ST_NO_ROOM;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            bank_next  = {1'b0, wanted_bank};
                            end_next   = wanted_bank;
                            state_next = S_BANK;
                        end
                    end
                    else
                    begin
                        bank_next  = {1'b0, first_bank_reg};
                        end_next   = hi_bank;
                        state_next = S_BANK;
                    end
                end
            end

            S_BANK:
            begin
                if ((bank_reg > {1'b0, end_reg})
                    || ({{(32 - BNUM_W - 1){1'b0}}, bank_off} >= 32'(MAX_BANKS)))
                begin
                    res_status_next = ST_NO_ROOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    bk_rd_en   = 1'b1;
                    idx_next   = BANK_W'(bank_off);
                    state_next = S_BANK_DATA;
                end
            end

            S_BANK_DATA:
            begin
                i_next     = '0;
                first_next = 1'b1;
                if (!bk_rd_data[CNT_W])
                begin
                    n_next     = CNT_W'(1);
                    seg_b_next = region_start_reg;
                    seg_z_next = region_length_reg;
                    a_next     = region_start_reg;
                    state_next = S_EVAL;
                end
                else if (stored_cnt == '0)
                begin
                    bank_next  = bank_reg + (BNUM_W + 1)'(1);
                    state_next = S_BANK;
                end
                else
                begin
                    n_next     = stored_cnt;
                    set_a_next = 1'b1;
                    state_next = S_SEG_RD;
                end
            end

            S_SEG_RD:
            begin
                seg_rd_en  = 1'b1;
                state_next = S_SEG_DATA;
            end

            S_SEG_DATA:
            begin
                seg_b_next = seg_rd_data[2*ADDR_W-1:ADDR_W];
                seg_z_next = seg_rd_data[ADDR_W-1:0];
                if (set_a_reg)
                begin
                    a_next = seg_rd_data[2*ADDR_W-1:ADDR_W];
                end
                state_next = first_reg ? S_EVAL : S_CHECK;
            end

            S_CHECK:
            begin
                if ({1'b0, a_reg} >= seg_end)
                begin
                    i_next     = i_inc;
                    set_a_next = 1'b0;
                    if (i_inc >= n_reg)
                    begin
                        bank_next  = bank_reg + (BNUM_W + 1)'(1);
                        state_next = S_BANK;
                    end
                    else
                    begin
                        state_next = S_SEG_RD;
                    end
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                first_next = 1'b0;
                if (fits)
                begin
                    state_next = S_FOUND;
                end
                else if (af_reg)
                begin
                    if (a_reg < waddr_reg)
                    begin
                        a_next     = waddr_reg;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        bank_next  = bank_reg + (BNUM_W + 1)'(1);
                        state_next = S_BANK;
                    end
                end
                else if (alf_reg)
                begin
                    if (next_align <= a_reg)
                    begin
                        bank_next  = bank_reg + (BNUM_W + 1)'(1);
                        state_next = S_BANK;
                    end
                    else
                    begin
                        a_next     = next_align;
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    i_next = i_inc;
                    if (i_inc >= n_reg)
                    begin
                        bank_next  = bank_reg + (BNUM_W + 1)'(1);
                        state_next = S_BANK;
                    end
                    else
                    begin
                        set_a_next = 1'b1;
                        state_next = S_SEG_RD;
                    end
                end
            end

            S_FOUND:
            begin
                split_next = !no_left && !no_right;
                if (no_left && no_right)
                begin
                    n_new_next = n_reg - CNT_W'(1);
                    k_next     = i_reg;
                    down_next  = 1'b1;
                    state_next = (i_inc < n_reg) ? S_SHIFT_RD : S_WR_CNT;
                end
                else if (!no_left && !no_right)
                begin
                    if (n_reg >= MAX_CNT)
                    begin
                        res_status_next = ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        n_new_next = n_reg + CNT_W'(1);
                        k_next     = n_reg;
                        down_next  = 1'b0;
                        state_next = (n_reg > i_inc) ? S_SHIFT_RD : S_WR_A;
                    end
                end
                else
                begin
                    n_new_next = n_reg;
                    state_next = S_WR_A;
                end
            end

            S_SHIFT_RD:
            begin
                seg_rd_en   = 1'b1;
                seg_rd_addr = down_reg ? {idx_reg, SEG_W'(k_reg + CNT_W'(1))}
                                       : {idx_reg, SEG_W'(k_reg - CNT_W'(1))};
                state_next  = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                seg_wr_en   = 1'b1;
                seg_wr_addr = {idx_reg, k_reg[SEG_W-1:0]};
                seg_wr_data = seg_rd_data;
                if (down_reg)
                begin
                    k_next     = k_reg + CNT_W'(1);
                    state_next = ((k_reg + CNT_W'(2)) < n_reg) ? S_SHIFT_RD : S_WR_CNT;
                end
                else
                begin
                    k_next     = k_reg - CNT_W'(1);
                    state_next = ((k_reg - CNT_W'(1)) > i_inc) ? S_SHIFT_RD : S_WR_A;
                end
            end

            S_WR_A:
            begin
                seg_wr_en = 1'b1;
                if (split_reg)
                begin
                    seg_wr_data = {seg_b_reg, a_reg - seg_b_reg};
                    state_next  = S_WR_B;
                end
                else
                begin
                    seg_wr_data = {(no_left ? seg_b_reg + size_reg : seg_b_reg),
                                   seg_z_reg - size_reg};
                    state_next  = S_WR_CNT;
                end
            end

            S_WR_B:
            begin
                seg_wr_en   = 1'b1;
                seg_wr_addr = {idx_reg, i_inc[SEG_W-1:0]};
                seg_wr_data = {a_plus[ADDR_W-1:0], ADDR_W'(seg_end - a_plus)};
                state_next  = S_WR_CNT;
            end

            S_WR_CNT:
            begin
                bk_wr_en        = 1'b1;
                res_status_next = ST_OK;
                res_addr_next   = a_reg;
                res_bank_next   = bank_reg[BNUM_W-1:0];
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_bank_next   = res_bank_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_idx_reg       <= '0;
            clr_result_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            region_start_reg  <= ADDR_W'(16384);
            region_length_reg <= ADDR_W'(16384);
            first_bank_reg    <= BNUM_W'(1);
            last_bank_reg     <= BNUM_W'(511);
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            clr_result_reg <= clr_result_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_REGION_START:  region_start_reg  <= cfg_data;
                    REG_REGION_LENGTH: region_length_reg <= cfg_data;
                    REG_FIRST_BANK:    first_bank_reg    <= cfg_data[BNUM_W-1:0];
                    REG_LAST_BANK:     last_bank_reg     <= cfg_data[BNUM_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        af_reg         <= af_next;
        waddr_reg      <= waddr_next;
        alf_reg        <= alf_next;
        mask_reg       <= mask_next;
        ofs_reg        <= ofs_next;
        bank_reg       <= bank_next;
        end_reg        <= end_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        n_new_reg      <= n_new_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        a_reg          <= a_next;
        seg_b_reg      <= seg_b_next;
        seg_z_reg      <= seg_z_next;
        first_reg      <= first_next;
        set_a_reg      <= set_a_next;
        down_reg       <= down_next;
        split_reg      <= split_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_bank_reg   <= res_bank_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_bank_reg   <= out_bank_next;
    end

endmodule
`default_nettype wire

// ----- test/banked_first_fit_placer_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// banked_first_fit_placer_test
// Checks place and clear items of the banked first-fit placer against a
// behavioral free-segment table, under random sender and receiver gaps and
// several region settings.
// ----------------------------------------------------------------------------
module banked_first_fit_placer_test;
    import bffp_pkg::*;

    localparam int NBANK = 512;
    localparam int NSEG = 16;
    localparam int LIMIT = 20000000;

    typedef struct packed {
        logic        act;
        logic [15:0] size;
        logic        bfix;
        logic [8:0]  bank;
        logic        afix;
        logic [15:0] addr;
        logic        alfix;
        logic [15:0] mask;
        logic [15:0] ofs;
    } request_t;

    typedef struct packed {
        status_t     st;
        logic [15:0] addr;
        logic [8:0]  bank;
    } placement_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [15:0] placed_address;
    logic [8:0] placed_bank;
    logic cfg_write = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    request_t cur = '0;
    logic in_ready_q = 1'b0;

    request_t pending_items[$];
    placement_t expected_placements[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int cycles = 0;

    // placer state
    logic [15:0] r_start = 16'd16384;
    logic [15:0] r_len = 16'd16384;
    logic [8:0] r_first = 9'd1;
    logic [8:0] r_last = 9'd511;
    logic [15:0] seg_b [NBANK][NSEG];
    logic [15:0] seg_z [NBANK][NSEG];
    int seg_n [NBANK];
    bit touched [NBANK];

    banked_first_fit_placer i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(cur.act), .request_size(cur.size), .bank_is_fixed(cur.bfix),
        .wanted_bank(cur.bank), .address_is_fixed(cur.afix),
        .wanted_address(cur.addr), .align_is_fixed(cur.alfix),
        .align_mask(cur.mask), .align_offset(cur.ofs),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .placed_address(placed_address),
        .placed_bank(placed_bank),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit fits_at(request_t r, int a, int b, int z);
        if (r.afix && r.addr != a) return 0;
        if (r.alfix && ((16'(a - r.ofs) & r.mask) != 0)) return 0;
        if (a < b) return 0;
        return a + r.size <= b + z;
    endfunction

    function automatic placement_t place_section(request_t r);
        placement_t p;
        int lo, hi, s, e, n, i, a, na, sb, sz, k, idx;
        int b [NSEG+1];
        int z [NSEG+1];
        bit nl, nr, found;
        p = '{ST_OK, 16'd0, 9'd0};
        if (r.act == ACT_CLEAR)
        begin
            foreach (touched[j]) touched[j] = 0;
            return p;
        end
        if (r.size == 0)
        begin
            p.addr = r.afix ? r.addr : r_start;
            p.bank = r.bfix ? r.bank : r_first;
            return p;
        end
        lo = r_first;
        hi = (r_last < lo) ? lo : r_last;
        s = lo;
        e = hi;
        if (r.bfix)
        begin
            if (r.bank < lo || r.bank > hi)
            begin
                p.st = ST_NO_ROOM;
                return p;
            end
            s = r.bank;
            e = r.bank;
        end
        for (int bk = s; bk <= e; bk++)
        begin
            idx = bk - lo;
            if (idx >= NBANK) break;
            if (!touched[idx])
            begin
                n = 1; b[0] = r_start; z[0] = r_len;
            end
            else
            begin
                n = seg_n[idx];
                for (int j = 0; j < n; j++)
                begin
                    b[j] = seg_b[idx][j]; z[j] = seg_z[idx][j];
                end
            end
            found = 0;
            i = 0;
            if (n > 0) a = b[0];
            while (i < n)
            begin
                if (fits_at(r, a, b[i], z[i]))
                begin
                    found = 1;
                    break;
                end
                if (r.afix)
                begin
                    if (a < r.addr) a = r.addr;
                    else break;
                end
                else if (r.alfix)
                begin
                    na = 16'((16'(a - r.ofs) & ~r.mask) + r.mask + 1 + r.ofs);
                    if (na <= a) break;
                    a = na;
                end
                else
                begin
                    i++;
                    if (i < n) a = b[i];
                end
                while (i < n && a >= b[i] + z[i]) i++;
            end
            if (!found) continue;
            sb = b[i];
            sz = z[i];
            nl = (sb == a);
            nr = (sb + sz == a + r.size);
            if (nl && nr)
            begin
                for (k = i; k + 1 < n; k++)
                begin
                    b[k] = b[k+1]; z[k] = z[k+1];
                end
                n--;
            end
            else if (!nl && !nr)
            begin
                if (n >= NSEG)
                begin
                    p.st = ST_TABLE_FULL;
                    return p;
                end
                for (k = n; k > i + 1; k--)
                begin
                    b[k] = b[k-1]; z[k] = z[k-1];
                end
                b[i+1] = 16'(a + r.size);
                z[i+1] = 16'(sb + sz - (a + r.size));
                z[i] = a - sb;
                n++;
            end
            else
            begin
                z[i] = 16'(sz - r.size);
                if (nl) b[i] = 16'(sb + r.size);
            end
            for (int j = 0; j < n; j++)
            begin
                seg_b[idx][j] = b[j]; seg_z[idx][j] = z[j];
            end
            seg_n[idx] = n;
            touched[idx] = 1;
            p.addr = a;
            p.bank = bk;
            return p;
        end
        p.st = ST_NO_ROOM;
        return p;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_q)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // acceptance seen at the last rising edge
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        in_ready_q <= in_valid && in_ready;
        if (in_valid && in_ready)
            expected_placements.push_back(place_section(cur));
        if (out_valid && out_ready)
        begin
            if (expected_placements.size() == 0)
            begin
                $error("unexpected item: status %0d", status);
                errors++;
            end
            else
            begin
                placement_t x;
                x = expected_placements.pop_front();
                if (status !== x.st)
                begin
                    $error("status: expected %0d, got %0d", x.st, status);
                    errors++;
                end
                if (placed_address !== x.addr)
                begin
                    $error("placed_address: expected %0h, got %0h", x.addr, placed_address);
                    errors++;
                end
                if (placed_bank !== x.bank)
                begin
                    $error("placed_bank: expected %0d, got %0d", x.bank, placed_bank);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_REGION_START:  r_start = val;
            REG_REGION_LENGTH: r_len = val;
            REG_FIRST_BANK:    r_first = val[8:0];
            default:           r_last = val[8:0];
        endcase
    endtask

    task automatic drain;
        wait (pending_items.size() == 0 && !in_valid);
        while (expected_placements.size() != 0) @(posedge clk);
        repeat (NBANK * 4) @(posedge clk);
    endtask

    function automatic request_t rand_place(int maxsz);
        request_t r;
        r.act = 1'b0;
        r.size = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(maxsz));
        r.bfix = ($urandom_range(3) == 0);
        r.bank = ($urandom_range(3) == 0) ? 9'($urandom) : 9'(r_first + $urandom_range(3));
        r.afix = ($urandom_range(5) == 0);
        r.addr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(r_start + $urandom_range(300));
        r.alfix = ($urandom_range(2) == 0);
        r.mask = ($urandom_range(9) == 0) ? 16'($urandom) : 16'((1 << $urandom_range(6)) - 1);
        r.ofs = ($urandom_range(5) == 0) ? 16'($urandom) : 16'($urandom_range(7));
        return r;
    endfunction

    task automatic random_phase(int count, int maxsz);
        request_t r;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(39) == 0)
            begin
                r = '0;
                r.act = ACT_CLEAR;
                r.size = 16'($urandom);
                pending_items.push_back(r);
            end
            else
                pending_items.push_back(rand_place(maxsz));
        end
    endtask

    initial
    begin
        request_t r;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // small region, few banks
        write_reg(REG_REGION_START, 16'h0100);
        write_reg(REG_REGION_LENGTH, 16'h0200);
        write_reg(REG_FIRST_BANK, 16'd3);
        write_reg(REG_LAST_BANK, 16'd5);
        send_idle_pct = 7;
        recv_idle_pct = 73;
        // directed: zero size, exact fit, fixed address split, alignment,
        // fixed bank out of range, table full via many splits, clear
        r = '0; pending_items.push_back(r);
        r = '0; r.afix = 1; r.addr = 16'hFFFF; r.bfix = 1; r.bank = 9'h1FF;
        pending_items.push_back(r);
        r = '0; r.size = 16'h0200; r.bfix = 1; r.bank = 9'd3; pending_items.push_back(r);
        r = '0; r.size = 16'h0010; r.bfix = 1; r.bank = 9'd3; pending_items.push_back(r);
        r = '0; r.size = 16'hFFFF; pending_items.push_back(r);
        r = '0; r.size = 16'h0001; r.bfix = 1; r.bank = 9'd9; pending_items.push_back(r);
        r = '0; r.size = 16'h0008; r.alfix = 1; r.mask = 16'h003F; r.ofs = 16'h0004;
        pending_items.push_back(r);
        r = '0; r.size = 16'h0004; r.alfix = 1; r.mask = 16'hFFFF; r.ofs = 16'hFFFF;
        pending_items.push_back(r);
        for (int k = 0; k < 17; k++)
        begin
            r = '0; r.size = 16'd2; r.bfix = 1; r.bank = 9'd4; r.afix = 1;
            r.addr = 16'(16'h0101 + 4 * k);
            r.alfix = (k == 3); r.mask = 16'h0001;
            pending_items.push_back(r);
        end
        r = '0; r.act = ACT_CLEAR; pending_items.push_back(r);
        random_phase(300, 64);
        drain();
        // pause until all results are in, then wide region at the top of memory
        write_reg(REG_REGION_START, 16'hFF00);
        write_reg(REG_REGION_LENGTH, 16'hFFFF);
        write_reg(REG_FIRST_BANK, 16'd0);
        write_reg(REG_LAST_BANK, 16'd1);
        send_idle_pct = 73;
        recv_idle_pct = 7;
        r = '0; r.act = ACT_CLEAR; pending_items.push_back(r);
        random_phase(300, 512);
        drain();
        // last below first, high bank numbers, empty region
        write_reg(REG_REGION_START, 16'h0000);
        write_reg(REG_REGION_LENGTH, 16'h0000);
        write_reg(REG_FIRST_BANK, 16'd511);
        write_reg(REG_LAST_BANK, 16'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(50, 16);
        drain();
        write_reg(REG_REGION_START, 16'h8000);
        write_reg(REG_REGION_LENGTH, 16'h0400);
        write_reg(REG_FIRST_BANK, 16'd509);
        write_reg(REG_LAST_BANK, 16'd511);
        r = '0; r.act = ACT_CLEAR; pending_items.push_back(r);
        random_phase(350, 128);
        drain();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/bffp_pkg.sv
design/bffp_ram.sv
design/banked_first_fit_placer.sv
test/banked_first_fit_placer_test.sv
